[src/hsvgp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvgp_pkg
// Shared constants, types and arithmetic helpers for the HSV picker generator.
// ----------------------------------------------------------------------------
package hsvgp_pkg;

   // Picker geometry: coordinates run 0..SIDE-1
   localparam int SIDE = 256;
   localparam logic [7:0] MAX_COORD = 8'(SIDE - 1);

   // Configuration register indexes
   localparam logic [1:0] REG_BASE_RED   = 2'd0;
   localparam logic [1:0] REG_BASE_GREEN = 2'd1;
   localparam logic [1:0] REG_BASE_BLUE  = 2'd2;

   localparam logic [7:0] BASE_RED_RESET   = 8'd0;
   localparam logic [7:0] BASE_GREEN_RESET = 8'd0;
   localparam logic [7:0] BASE_BLUE_RESET  = 8'd255;

   // Hue offsets in sextants
   localparam logic [2:0] HUE_OFS_0 = 3'd0;
   localparam logic [2:0] HUE_OFS_2 = 3'd2;
   localparam logic [2:0] HUE_OFS_4 = 3'd4;
   localparam logic [2:0] HUE_OFS_6 = 3'd6;

   // Hue sectors
   localparam logic [2:0] SECT_0 = 3'd0;
   localparam logic [2:0] SECT_1 = 3'd1;
   localparam logic [2:0] SECT_2 = 3'd2;
   localparam logic [2:0] SECT_3 = 3'd3;
   localparam logic [2:0] SECT_4 = 3'd4;
   localparam logic [2:0] SECT_6 = 3'd6;

   // 255 in Q8.16
   localparam logic [23:0] FULL_SCALE = 24'(255 * 65536);
   localparam logic [16:0] FRAC_ONE   = 17'(65536);

   typedef struct packed {
      logic [7:0] row;
      logic [7:0] col;
      logic [2:0] hue_ofs;
      logic       neg;
      logic       gray;
   } item_type;

   typedef struct packed {
      logic       bit_out;
      logic [7:0] rem;
   } div_step_type;

   // One restoring division step; x < 2*den on entry
   function automatic div_step_type div_step(input logic [8:0] x, input logic [7:0] den);
      div_step_type res;
      logic [8:0]   diff;
      logic         ge;
      ge          = (x >= {1'b0, den});
      diff        = x - {1'b0, den};
      res.bit_out = ge;
      res.rem     = ge ? diff[7:0] : x[7:0];
      return res;
   endfunction

   // floor(y / 255), exact for y < 65280
   function automatic logic [7:0] div255(input logic [15:0] y);
      logic [16:0] acc;
      acc = {1'b0, y} + 17'(y[15:8]) + 17'd1;
      return acc[15:8];
   endfunction

endpackage

[src/hsv_gradient_pixel_generator.sv]
`timescale 1ns / 1ps
// Throughput: one pixel per clock; busy stays low, a new start is taken every cycle.
// Latency is set by the nine-stage pipeline: hue setup, three hue divider
// stages, sector pick, two multiply stages with a subtract between, output.
// Reset (synchronous) empties the pipeline and loads the base color 0/0/255.
// ----------------------------------------------------------------------------
// hsv_gradient_pixel_generator
// Saturation/value picker: row and column to RGB under a configured hue.
// ----------------------------------------------------------------------------
module hsv_gradient_pixel_generator
   import hsvgp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_row,
   input  logic [7:0] req_column,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   // configuration
   logic [7:0] base_red_ff, base_green_ff, base_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_red_ff   <= BASE_RED_RESET;
         base_green_ff <= BASE_GREEN_RESET;
         base_blue_ff  <= BASE_BLUE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_BASE_RED:   base_red_ff   <= csr_write_data;
            REG_BASE_GREEN: base_green_ff <= csr_write_data;
            REG_BASE_BLUE:  base_blue_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic       accept;
   logic [7:0] valid_ff;
   logic       rsp_valid_ff;

   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[6:0], accept};
         rsp_valid_ff <= valid_ff[7];
      end
   end

   // stage 1: chroma, hue branch, numerator
   logic [7:0] mx, mn;
   logic [7:0] s1_num_in, s1_chroma_in;
   item_type   s1_item_in;
   logic [7:0] s1_num_ff, s1_chroma_ff;
   item_type   s1_item_ff;

   always_comb begin
      mx = base_red_ff;
      mn = base_red_ff;
      if (base_green_ff > mx) mx = base_green_ff;
      if (base_blue_ff > mx)  mx = base_blue_ff;
      if (base_green_ff < mn) mn = base_green_ff;
      if (base_blue_ff < mn)  mn = base_blue_ff;
      s1_chroma_in    = mx - mn;
      s1_item_in.row  = (req_row > MAX_COORD) ? MAX_COORD : req_row;
      s1_item_in.col  = (req_column > MAX_COORD) ? MAX_COORD : req_column;
      s1_item_in.gray = (mx == mn);
      if (mx == base_red_ff) begin
         s1_item_in.neg     = (base_green_ff < base_blue_ff);
         s1_item_in.hue_ofs = s1_item_in.neg ? HUE_OFS_6 : HUE_OFS_0;
         s1_num_in          = s1_item_in.neg ? base_blue_ff - base_green_ff
                                             : base_green_ff - base_blue_ff;
      end else if (mx == base_green_ff) begin
         s1_item_in.neg     = (base_blue_ff < base_red_ff);
         s1_item_in.hue_ofs = HUE_OFS_2;
         s1_num_in          = s1_item_in.neg ? base_red_ff - base_blue_ff
                                             : base_blue_ff - base_red_ff;
      end else begin
         s1_item_in.neg     = (base_red_ff < base_green_ff);
         s1_item_in.hue_ofs = HUE_OFS_4;
         s1_num_in          = s1_item_in.neg ? base_green_ff - base_red_ff
                                             : base_red_ff - base_green_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_num_ff    <= s1_num_in;
      s1_chroma_ff <= s1_chroma_in;
      s1_item_ff   <= s1_item_in;
   end

   // stages 2..4: num * 65536 / chroma, 17 quotient bits
   div_step_type st2, st3, st4;
   logic [16:0]  s2_quot_in, s3_quot_in, s4_quot_in;
   logic [7:0]   s2_rem_in, s3_rem_in, s4_rem_in;
   logic [16:0]  s2_quot_ff, s3_quot_ff, s4_quot_ff;
   logic [7:0]   s2_rem_ff, s3_rem_ff, s4_rem_ff;
   logic [7:0]   s2_chroma_ff, s3_chroma_ff;
   item_type     s2_item_ff, s3_item_ff, s4_item_ff;

   always_comb begin
      st2        = div_step({1'b0, s1_num_ff}, s1_chroma_ff);
      s2_quot_in = {16'd0, st2.bit_out};
      s2_rem_in  = st2.rem;
      for (int k = 0; k < 5; k++) begin
         st2        = div_step({s2_rem_in, 1'b0}, s1_chroma_ff);
         s2_quot_in = {s2_quot_in[15:0], st2.bit_out};
         s2_rem_in  = st2.rem;
      end
   end

   always_comb begin
      s3_quot_in = s2_quot_ff;
      s3_rem_in  = s2_rem_ff;
      st3        = '0;
      for (int k = 0; k < 6; k++) begin
         st3        = div_step({s3_rem_in, 1'b0}, s2_chroma_ff);
         s3_quot_in = {s3_quot_in[15:0], st3.bit_out};
         s3_rem_in  = st3.rem;
      end
   end

   always_comb begin
      s4_quot_in = s3_quot_ff;
      s4_rem_in  = s3_rem_ff;
      st4        = '0;
      for (int k = 0; k < 5; k++) begin
         st4        = div_step({s4_rem_in, 1'b0}, s3_chroma_ff);
         s4_quot_in = {s4_quot_in[15:0], st4.bit_out};
         s4_rem_in  = st4.rem;
      end
   end

   always_ff @(posedge clock) begin
      s2_quot_ff   <= s2_quot_in;
      s2_rem_ff    <= s2_rem_in;
      s2_chroma_ff <= s1_chroma_ff;
      s2_item_ff   <= s1_item_ff;
      s3_quot_ff   <= s3_quot_in;
      s3_rem_ff    <= s3_rem_in;
      s3_chroma_ff <= s2_chroma_ff;
      s3_item_ff   <= s2_item_ff;
      s4_quot_ff   <= s4_quot_in;
      s4_rem_ff    <= s4_rem_in;
      s4_item_ff   <= s3_item_ff;
   end

   // stage 5: hue in Q3.16, sector, fraction, saturation
   logic [16:0] frac_ceil;
   logic [18:0] hue;
   logic [2:0]  s5_sector_in, s5_sector_ff;
   logic [15:0] s5_frac_ff;
   logic [7:0]  s5_sat_in, s5_sat_ff;
   logic [7:0]  s5_row_ff, s5_col_ff;
   logic        s5_gray_ff;

   always_comb begin
      frac_ceil = s4_quot_ff + 17'(s4_rem_ff != 8'd0);
      if (s4_item_ff.neg) begin
         hue = {s4_item_ff.hue_ofs, 16'd0} - 19'(frac_ceil);
      end else begin
         hue = {s4_item_ff.hue_ofs, 16'd0} + 19'(s4_quot_ff);
      end
      s5_sector_in = (hue[18:16] >= SECT_6) ? SECT_0 : hue[18:16];
      s5_sat_in    = (s4_item_ff.row == 8'd0) ? 8'd0 : s4_item_ff.col;
   end

   always_ff @(posedge clock) begin
      s5_sector_ff <= s5_sector_in;
      s5_frac_ff   <= hue[15:0];
      s5_sat_ff    <= s5_sat_in;
      s5_row_ff    <= s4_item_ff.row;
      s5_col_ff    <= s4_item_ff.col;
      s5_gray_ff   <= s4_item_ff.gray;
   end

   // stage 6: saturation products
   logic [23:0] sg_full;
   logic [23:0] s6_sf_ff, s6_sg_ff;
   logic [15:0] s6_pnum_ff;
   logic [7:0]  s6_row_ff, s6_col_ff;
   logic [2:0]  s6_sector_ff;
   logic        s6_gray_ff;

   assign sg_full = 24'(s5_sat_ff) * (24'(FRAC_ONE) - 24'(s5_frac_ff));

   always_ff @(posedge clock) begin
      s6_sf_ff     <= 24'(s5_sat_ff) * 24'(s5_frac_ff);
      s6_sg_ff     <= sg_full;
      s6_pnum_ff   <= 16'(s5_row_ff) * 16'(MAX_COORD - s5_sat_ff);
      s6_row_ff    <= s5_row_ff;
      s6_col_ff    <= s5_col_ff;
      s6_sector_ff <= s5_sector_ff;
      s6_gray_ff   <= s5_gray_ff;
   end

   // stage 7: complements
   logic [23:0] s7_qf_ff, s7_tf_ff;
   logic [15:0] s7_pnum_ff;
   logic [7:0]  s7_row_ff, s7_col_ff;
   logic [2:0]  s7_sector_ff;
   logic        s7_gray_ff;

   always_ff @(posedge clock) begin
      s7_qf_ff     <= FULL_SCALE - s6_sf_ff;
      s7_tf_ff     <= FULL_SCALE - s6_sg_ff;
      s7_pnum_ff   <= s6_pnum_ff;
      s7_row_ff    <= s6_row_ff;
      s7_col_ff    <= s6_col_ff;
      s7_sector_ff <= s6_sector_ff;
      s7_gray_ff   <= s6_gray_ff;
   end

   // stage 8: value products, drop Q16 fraction
   logic [31:0] qnum_full, tnum_full;
   logic [15:0] s8_qnum_ff, s8_tnum_ff, s8_pnum_ff;
   logic [7:0]  s8_row_ff, s8_col_ff;
   logic [2:0]  s8_sector_ff;
   logic        s8_gray_ff;

   assign qnum_full = 32'(s7_row_ff) * 32'(s7_qf_ff);
   assign tnum_full = 32'(s7_row_ff) * 32'(s7_tf_ff);

   always_ff @(posedge clock) begin
      s8_qnum_ff   <= qnum_full[31:16];
      s8_tnum_ff   <= tnum_full[31:16];
      s8_pnum_ff   <= s7_pnum_ff;
      s8_row_ff    <= s7_row_ff;
      s8_col_ff    <= s7_col_ff;
      s8_sector_ff <= s7_sector_ff;
      s8_gray_ff   <= s7_gray_ff;
   end

   // stage 9: scale by 1/255, sector select, gray override
   logic [7:0] pv, qv, tv, gv;
   logic [7:0] rsp_out_red_in, rsp_out_green_in, rsp_out_blue_in;
   logic [7:0] rsp_out_red_ff, rsp_out_green_ff, rsp_out_blue_ff;

   always_comb begin
      pv = div255(s8_pnum_ff);
      qv = div255(s8_qnum_ff);
      tv = div255(s8_tnum_ff);
      gv = MAX_COORD - s8_col_ff;
      case (s8_sector_ff)
         SECT_0:  {rsp_out_red_in, rsp_out_green_in, rsp_out_blue_in} = {s8_row_ff, tv, pv};
         SECT_1:  {rsp_out_red_in, rsp_out_green_in, rsp_out_blue_in} = {qv, s8_row_ff, pv};
         SECT_2:  {rsp_out_red_in, rsp_out_green_in, rsp_out_blue_in} = {pv, s8_row_ff, tv};
         SECT_3:  {rsp_out_red_in, rsp_out_green_in, rsp_out_blue_in} = {pv, qv, s8_row_ff};
         SECT_4:  {rsp_out_red_in, rsp_out_green_in, rsp_out_blue_in} = {tv, pv, s8_row_ff};
         default: {rsp_out_red_in, rsp_out_green_in, rsp_out_blue_in} = {s8_row_ff, pv, qv};
      endcase
      if (s8_gray_ff) begin
         rsp_out_red_in   = gv;
         rsp_out_green_in = gv;
         rsp_out_blue_in  = gv;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_red_ff   <= rsp_out_red_in;
      rsp_out_green_ff <= rsp_out_green_in;
      rsp_out_blue_ff  <= rsp_out_blue_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_out_red_ff;
   assign rsp_out_green = rsp_out_green_ff;
   assign rsp_out_blue  = rsp_out_blue_ff;

endmodule

[src/hsvgp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvgp_checker
// Port-level checks for the HSV picker generator, bound to the top level.
// ----------------------------------------------------------------------------
module hsvgp_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [7:0] req_row,
   input logic [7:0] req_column,
   input logic       rsp_valid,
   input logic [7:0] rsp_out_red,
   input logic [7:0] rsp_out_green,
   input logic [7:0] rsp_out_blue
);

   // every start transfer gives a result on rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##9 rsp_valid)
      else $error("result missing nine cycles after start transfer");

   // row zero or column zero has no saturation: all channels equal
   a_unsaturated: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_row == 8'd0 || req_column == 8'd0)) |-> ##9
      (rsp_out_red == rsp_out_green && rsp_out_green == rsp_out_blue))
      else $error("unsaturated pixel is not gray");

   // a colored pixel carries the value (the row) in some channel
   a_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !(rsp_out_red == rsp_out_green && rsp_out_green == rsp_out_blue))
      |-> (rsp_out_red == $past(req_row, 9) || rsp_out_green == $past(req_row, 9) ||
           rsp_out_blue == $past(req_row, 9)))
      else $error("colored pixel does not hold the value channel");

endmodule

bind hsv_gradient_pixel_generator hsvgp_checker u_hsvgp_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Runs the HSV picker pixel generator against its own predictor. It changes
// the base color only while the pipeline is empty. For each start transfer it
// works out the RGB pixel and checks each strobed result in order.
// ----------------------------------------------------------------------------
module testbench;
   import hsvgp_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int         LATENCY    = 9;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         SEGMENTS   = 21;
   localparam int         SEGMENT_ITEMS = 36;

   typedef struct {
      logic [7:0] row;
      logic [7:0] column;
      logic       wait_drain;
   } coord_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [7:0] req_row = '0;
   logic [7:0] req_column = '0;
   logic       rsp_valid;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_write_data = '0;

   logic [7:0] hue_red   = BASE_RED_RESET;
   logic [7:0] hue_green = BASE_GREEN_RESET;
   logic [7:0] hue_blue  = BASE_BLUE_RESET;

   coord_type pending_coords[$];
   pixel_type expected_colors[$];
   int        idle_pct = 0;
   int        mismatches = 0;
   int        pixels_checked = 0;
   int        colors_used = 1;
   int        cycle_count = 0;

   hsv_gradient_pixel_generator DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_row          (req_row),
      .req_column       (req_column),
      .rsp_valid        (rsp_valid),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Saturation/value picker pixel under the current base color
   function automatic pixel_type hsv_pixel(input logic [7:0] row_in, input logic [7:0] col_in);
      longint unsigned d;
      longint unsigned r, g, b, mx, mn, c, hq, sector, f, s;
      longint unsigned base, den, v, p, q, t, gray;
      pixel_type px;
      d  = 255;
      r  = hue_red;
      g  = hue_green;
      b  = hue_blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      if (c == 0) begin
         gray = 255 - (col_in * 255) / d;
         px.red   = gray[7:0];
         px.green = gray[7:0];
         px.blue  = gray[7:0];
         return px;
      end
      // hue in Q3.16; descending slopes round up so the fraction stays floored
      if (mx == r) begin
         if (g >= b) hq = ((g - b) << 16) / c;
         else hq = 6 * 65536 - ((((b - g) << 16) + c - 1) / c);
      end else if (mx == g) begin
         if (b >= r) hq = 2 * 65536 + ((b - r) << 16) / c;
         else hq = 2 * 65536 - ((((r - b) << 16) + c - 1) / c);
      end else begin
         if (r >= g) hq = 4 * 65536 + ((r - g) << 16) / c;
         else hq = 4 * 65536 - ((((g - r) << 16) + c - 1) / c);
      end
      sector = hq >> 16;
      f = hq & 64'hFFFF;
      if (sector >= 6) sector = 0;
      s    = (row_in == 0) ? 0 : col_in;
      base = 255 * row_in;
      den  = d * d * 65536;
      v = base / d;
      p = (base * (d - s)) / (d * d);
      q = (base * (d * 65536 - s * f)) / den;
      t = (base * (d * 65536 - s * (65536 - f))) / den;
      case (sector)
         0: begin
            px.red = v[7:0]; px.green = t[7:0]; px.blue = p[7:0];
         end
         1: begin
            px.red = q[7:0]; px.green = v[7:0]; px.blue = p[7:0];
         end
         2: begin
            px.red = p[7:0]; px.green = v[7:0]; px.blue = t[7:0];
         end
         3: begin
            px.red = p[7:0]; px.green = q[7:0]; px.blue = v[7:0];
         end
         4: begin
            px.red = t[7:0]; px.green = p[7:0]; px.blue = v[7:0];
         end
         default: begin
            px.red = v[7:0]; px.green = p[7:0]; px.blue = q[7:0];
         end
      endcase
      return px;
   endfunction

   task automatic check_channel(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Driver: one start transfer per pending coordinate
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (pending_coords.size() != 0
                   && !(pending_coords[0].wait_drain && expected_colors.size() != 0)
                   && $urandom_range(99) >= idle_pct) begin
         start      <= 1'b1;
         req_row    <= pending_coords[0].row;
         req_column <= pending_coords[0].column;
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: check strobed results, record accepted transfers
   always @(posedge clock) begin
      pixel_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end else if (!reset) begin
         if (rsp_valid) begin
            if (expected_colors.size() == 0) begin
               $error("result with no transfer outstanding");
               mismatches++;
            end else begin
               want = expected_colors.pop_front();
               check_channel("out_red", want.red, rsp_out_red);
               check_channel("out_green", want.green, rsp_out_green);
               check_channel("out_blue", want.blue, rsp_out_blue);
               pixels_checked++;
            end
         end
         if (start && !busy) begin
            expected_colors.push_back(hsv_pixel(req_row, req_column));
            void'(pending_coords.pop_front());
         end
      end
   end

   task automatic wait_idle();
      while (pending_coords.size() != 0 || expected_colors.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_BASE_RED:   hue_red   = data;
         REG_BASE_GREEN: hue_green = data;
         REG_BASE_BLUE:  hue_blue  = data;
         default: ;
      endcase
   endtask

   task automatic add_coord(input logic [7:0] row, input logic [7:0] column,
                            input logic wait_drain);
      coord_type item;
      item.row        = row;
      item.column     = column;
      item.wait_drain = wait_drain;
      pending_coords.push_back(item);
   endtask

   function automatic logic [7:0] random_coord();
      if ($urandom_range(7) == 0)
         return $urandom_range(1) ? 8'd255 - 8'($urandom_range(1)) : 8'($urandom_range(1));
      return 8'($urandom_range(255));
   endfunction

   initial begin
      logic [23:0] color;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners and interior points under the reset color
      idle_pct = 24;
      add_coord(8'd0, 8'd0, 1'b0);
      add_coord(8'd0, 8'd255, 1'b0);
      add_coord(8'd255, 8'd0, 1'b0);
      add_coord(8'd255, 8'd255, 1'b0);
      add_coord(8'd1, 8'd1, 1'b0);
      add_coord(8'd1, 8'd255, 1'b0);
      add_coord(8'd255, 8'd1, 1'b0);
      add_coord(8'd254, 8'd254, 1'b1);
      add_coord(8'd128, 8'd128, 1'b0);
      add_coord(8'd127, 8'd128, 1'b0);
      add_coord(8'hAA, 8'h55, 1'b0);
      add_coord(8'h55, 8'hAA, 1'b0);
      add_coord(8'd0, 8'd77, 1'b0);
      add_coord(8'd200, 8'd0, 1'b0);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_idle();
         case (seg)
            0:  color = 24'h000000;
            1:  color = 24'hFFFFFF;
            2:  color = 24'h808080;
            3:  color = 24'hFF0000;
            4:  color = 24'h00FF00;
            5:  color = 24'h0000FF;
            6:  color = 24'hFFFF00;
            7:  color = 24'h00FFFF;
            8:  color = 24'hFF00FF;
            9:  color = 24'hFF0001;
            10: color = 24'h01FF00;
            11: color = 24'hC83278;
            default: begin
               color = 24'($urandom);
               if (seg % 4 == 0) color = {3{color[7:0]}};
            end
         endcase
         if (seg < 7) idle_pct = 24;
         else if (seg < 14) idle_pct = 63;
         else idle_pct = 0;
         // writes to the spare index must leave the color alone
         if (seg % 5 == 0) write_reg(REG_UNUSED, 8'($urandom));
         write_reg(REG_BASE_RED, color[23:16]);
         write_reg(REG_BASE_GREEN, color[15:8]);
         write_reg(REG_BASE_BLUE, color[7:0]);
         colors_used++;
         for (int i = 0; i < SEGMENT_ITEMS; i++)
            add_coord(random_coord(), random_coord(), $urandom_range(49) == 0);
      end

      wait_idle();
      repeat (2 * LATENCY) @(posedge clock);
      $display("%0d pixels checked under %0d base colors", pixels_checked, colors_used);
      $display("gray, primary, tied and random hues; sender idle at 24, 63 and 0 percent");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
